### rtl/idxl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idxl_pkg
// Shared types and constants for the indexed list engine: operation and
// status codes, field widths and stream packing widths.
// ----------------------------------------------------------------------------
package idxl_pkg;

  localparam int OP_W       = 4;
  localparam int POS_W      = 9;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 3;
  localparam int RPOS_W     = 8;
  localparam int CNT_OUT_W  = 9;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_END     = 4'd0,
    OP_ADD_FRONT   = 4'd1,
    OP_ADD_AT      = 4'd2,
    OP_REMOVE_END  = 4'd3,
    OP_REMOVE_FRONT = 4'd4,
    OP_REMOVE_AT   = 4'd5,
    OP_CLEAR       = 4'd6,
    OP_CONTAINS    = 4'd7,
    OP_GET         = 4'd8,
    OP_SEARCH      = 4'd9,
    OP_SET         = 4'd10
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage : idxl_pkg
`default_nettype wire

### rtl/idxl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idxl_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module idxl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : idxl_ram
`default_nettype wire

### rtl/indexed_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit values with insert, remove,
// clear, get, set, contains and search operations, one result per item.
// ----------------------------------------------------------------------------
// The list lives in a single-port-pair RAM (one read and one write a cycle),
// and one sequencer walks it one entry per cycle. An insert moves each entry
// from the end down to its position one place up, then writes the new value;
// a remove moves each entry after its position one place down; contains and
// search read from the front and stop at the first match; get reads one
// entry; set, clear and error cases need no walk. A new item is taken only
// when the sequencer is idle, from the same cycle its result turns valid, so
// the longest cases are an insert at the front of a list holding CAPACITY - 1
// entries and a contains or search over a full list with no match; a finished
// result may still wait in the output register meanwhile.
// The RAM needs no clearing pass after reset: only entries below the
// element count are ever read.
module indexed_list_engine_unit #(
  parameter int CAPACITY = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // operation[3:0], position[12:4], value[44:13], zero fill
  input  wire logic [idxl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[2:0], found[3], result_value[35:4], result_position[43:36],
  // element_count[52:44], zero fill
  output logic      [idxl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > idxl_pkg::POS_W) ? CNT_W : idxl_pkg::POS_W;
  localparam int CX_W   = (CNT_W > idxl_pkg::CNT_OUT_W) ? CNT_W : idxl_pkg::CNT_OUT_W;
  localparam int RX_W   = (ADDR_W > idxl_pkg::RPOS_W) ? ADDR_W : idxl_pkg::RPOS_W;
  localparam int PAD_W  = idxl_pkg::OUT_DATA_W - idxl_pkg::ST_W - 1 - idxl_pkg::VAL_W
                          - idxl_pkg::RPOS_W - idxl_pkg::CNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_REM,
    S_SRCH,
    S_GET,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         issue_r, issue_nxt;
  logic                         pend_r, pend_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic [ADDR_W-1:0]            lim_r, lim_nxt;
  logic [ADDR_W-1:0]            wa_r, wa_nxt;
  logic [idxl_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic                         is_search_r, is_search_nxt;
  idxl_pkg::status_t            res_status_r, res_status_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [idxl_pkg::VAL_W-1:0]   res_value_r, res_value_nxt;
  logic [ADDR_W-1:0]            res_pos_r, res_pos_nxt;
  logic [idxl_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [idxl_pkg::VAL_W-1:0]   mem_wd;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_ra;
  logic [idxl_pkg::VAL_W-1:0]   mem_rd;

  logic                         in_fire;
  idxl_pkg::op_t                in_op;
  logic [idxl_pkg::POS_W-1:0]   in_pos;
  logic [idxl_pkg::VAL_W-1:0]   in_val;
  logic [CMP_W-1:0]             pos_x;
  logic [CMP_W-1:0]             cnt_x;
  logic [CMP_W-1:0]             last_x;
  logic [CMP_W-1:0]             ins_x;
  logic [CMP_W-1:0]             rem_x;
  logic                         list_empty;
  logic                         list_full;
  logic [CX_W-1:0]              cnt_wide;
  logic [RX_W-1:0]              rpos_wide;

  assign in_op      = idxl_pkg::op_t'(in_tdata[3:0]);
  assign in_pos     = in_tdata[12:4];
  assign in_val     = in_tdata[44:13];
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign pos_x      = CMP_W'(in_pos);
  assign cnt_x      = CMP_W'(cnt_r);
  assign last_x     = cnt_x - CMP_W'(1);
  assign list_empty = (cnt_r == '0);
  assign list_full  = (cnt_r == CNT_W'(CAPACITY));
  assign cnt_wide   = CX_W'(cnt_r);
  assign rpos_wide  = RX_W'(res_pos_r);

  always_comb begin
    unique case (in_op)
      idxl_pkg::OP_ADD_END:   ins_x = cnt_x;
      idxl_pkg::OP_ADD_FRONT: ins_x = '0;
      default:                ins_x = pos_x;
    endcase
    unique case (in_op)
      idxl_pkg::OP_REMOVE_END:   rem_x = last_x;
      idxl_pkg::OP_REMOVE_FRONT: rem_x = '0;
      default:                   rem_x = pos_x;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    wa_nxt         = wa_r;
    val_nxt        = val_r;
    is_search_nxt  = is_search_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = wa_r;
    mem_wd         = val_r;
    mem_re         = 1'b0;
    mem_ra         = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt        = in_val;
          is_search_nxt  = (in_op == idxl_pkg::OP_SEARCH);
          res_status_nxt = idxl_pkg::ST_OK;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_pos_nxt    = '0;
          state_nxt      = S_DONE;
          unique case (in_op)
            idxl_pkg::OP_ADD_END, idxl_pkg::OP_ADD_FRONT, idxl_pkg::OP_ADD_AT: begin
              if (ins_x > cnt_x) begin
                res_status_nxt = idxl_pkg::ST_RANGE;
              end else if (list_full) begin
                res_status_nxt = idxl_pkg::ST_FULL;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
                lim_nxt = ADDR_W'(ins_x);
                if (ins_x == cnt_x) begin
                  state_nxt = S_INS_WR;
                end else begin
                  idx_nxt   = ADDR_W'(last_x);
                  issue_nxt = 1'b1;
                  pend_nxt  = 1'b0;
                  state_nxt = S_INS;
                end
              end
            end
            idxl_pkg::OP_REMOVE_END, idxl_pkg::OP_REMOVE_FRONT,
            idxl_pkg::OP_REMOVE_AT: begin
              if (list_empty) begin
                res_status_nxt = idxl_pkg::ST_EMPTY;
              end else if (rem_x >= cnt_x) begin
                res_status_nxt = idxl_pkg::ST_RANGE;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
                if (rem_x != last_x) begin
                  idx_nxt   = ADDR_W'(rem_x + CMP_W'(1));
                  lim_nxt   = ADDR_W'(last_x);
                  issue_nxt = 1'b1;
                  pend_nxt  = 1'b0;
                  state_nxt = S_REM;
                end
              end
            end
            idxl_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            idxl_pkg::OP_CONTAINS, idxl_pkg::OP_SEARCH: begin
              if (list_empty) begin
                if (in_op == idxl_pkg::OP_SEARCH) begin
                  res_status_nxt = idxl_pkg::ST_NOTFOUND;
                end
              end else begin
                idx_nxt   = '0;
                lim_nxt   = ADDR_W'(last_x);
                issue_nxt = 1'b1;
                pend_nxt  = 1'b0;
                state_nxt = S_SRCH;
              end
            end
            idxl_pkg::OP_GET, idxl_pkg::OP_SET: begin
              if (list_empty) begin
                res_status_nxt = idxl_pkg::ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status_nxt = idxl_pkg::ST_RANGE;
              end else if (in_op == idxl_pkg::OP_GET) begin
                mem_re    = 1'b1;
                mem_ra    = ADDR_W'(in_pos);
                state_nxt = S_GET;
              end else begin
                mem_we = 1'b1;
                mem_wa = ADDR_W'(in_pos);
                mem_wd = in_val;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wd = mem_rd;
        end
        if (issue_r) begin
          mem_re   = 1'b1;
          wa_nxt   = idx_r + ADDR_W'(1);
          pend_nxt = 1'b1;
          if (idx_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wa    = lim_r;
        state_nxt = S_DONE;
      end

      S_REM: begin
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wd = mem_rd;
        end
        if (issue_r) begin
          mem_re   = 1'b1;
          wa_nxt   = idx_r - ADDR_W'(1);
          pend_nxt = 1'b1;
          if (idx_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_SRCH: begin
        if (pend_r && (mem_rd == val_r)) begin
          issue_nxt     = 1'b0;
          pend_nxt      = 1'b0;
          res_found_nxt = 1'b1;
          if (is_search_r) begin
            res_pos_nxt = wa_r;
          end
          state_nxt = S_DONE;
        end else if (issue_r) begin
          mem_re   = 1'b1;
          wa_nxt   = idx_r;
          pend_nxt = 1'b1;
          if (idx_r == lim_r) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (is_search_r) begin
            res_status_nxt = idxl_pkg::ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end
      end

      S_GET: begin
        res_value_nxt = mem_rd;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{PAD_W{1'b0}},
                           cnt_wide[idxl_pkg::CNT_OUT_W-1:0],
                           rpos_wide[idxl_pkg::RPOS_W-1:0],
                           res_value_r,
                           res_found_r,
                           res_status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      lim_r        <= lim_nxt;
      wa_r         <= wa_nxt;
      val_r        <= val_nxt;
      is_search_r  <= is_search_nxt;
      res_status_r <= res_status_nxt;
      res_found_r  <= res_found_nxt;
      res_value_r  <= res_value_nxt;
      res_pos_r    <= res_pos_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  idxl_ram #(
    .WIDTH (idxl_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == idxl_pkg::OP_CLEAR) |=> (cnt_r == '0))
    else $error("clear did not empty the list");

  a_walk_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS || state_r == S_REM) && issue_r && (idx_r == lim_r)
    |=> !issue_r)
    else $error("shift walk ran past its end");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_r && !issue_r)
    else $error("read pipeline busy while idle");

endmodule : indexed_list_engine_unit
`default_nettype wire

### tb/indexed_list_engine_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine_unit_test
// Self-checking bench for the indexed list engine. A directed pass covers the
// empty and out-of-range cases, then random runs fill to full, churn and drain
// the list under varying backpressure. A shadow list predicts every result.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit_test;

  localparam int          LIST_DEPTH = 256;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 300;
  localparam logic [31:0] MARK_BASE = 32'h5A00_0000;

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIX, GEN_NOISE} gen_mode_t;

  typedef struct packed {
    idxl_pkg::op_t              op;
    logic [idxl_pkg::POS_W-1:0] pos;
    logic [idxl_pkg::VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    idxl_pkg::status_t              status;
    logic                           found;
    logic [idxl_pkg::VAL_W-1:0]     value;
    logic [idxl_pkg::RPOS_W-1:0]    pos;
    logic [idxl_pkg::CNT_OUT_W-1:0] count;
  } list_reply_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // operation[3:0], position[12:4], value[44:13], zero fill
  logic [idxl_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // status[2:0], found[3], result_value[35:4], result_position[43:36],
  // element_count[52:44], zero fill
  logic [idxl_pkg::OUT_DATA_W-1:0] out_tdata;

  list_cmd_t   pending_cmds[$];
  list_reply_t expected_replies[$];
  list_cmd_t   next_cmd;
  list_reply_t want;
  logic        in_fire = 1'b0;

  logic [31:0] shadow_list [0:LIST_DEPTH-1];
  int unsigned shadow_count = 0;
  int unsigned gen_count = 0;

  int send_idle_pct = 24;
  int recv_idle_pct = 72;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int failures = 0;

  indexed_list_engine_unit #(.CAPACITY(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow list operations
  function automatic idxl_pkg::status_t shadow_insert(int unsigned at, logic [31:0] v);
    int unsigned i;
    if (at > shadow_count) return idxl_pkg::ST_RANGE;
    if (shadow_count >= LIST_DEPTH) return idxl_pkg::ST_FULL;
    for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = v;
    shadow_count++;
    return idxl_pkg::ST_OK;
  endfunction

  function automatic idxl_pkg::status_t shadow_remove(int unsigned at);
    int unsigned i;
    if (shadow_count == 0) return idxl_pkg::ST_EMPTY;
    if (at >= shadow_count) return idxl_pkg::ST_RANGE;
    for (i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return idxl_pkg::ST_OK;
  endfunction

  function automatic int shadow_find(logic [31:0] v);
    int i;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_list[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic list_reply_t apply_cmd(list_cmd_t c);
    list_reply_t r;
    int          hit;
    r.status = idxl_pkg::ST_OK;
    r.found = 1'b0;
    r.value = '0;
    r.pos = '0;
    case (c.op)
      idxl_pkg::OP_ADD_END:      r.status = shadow_insert(shadow_count, c.value);
      idxl_pkg::OP_ADD_FRONT:    r.status = shadow_insert(0, c.value);
      idxl_pkg::OP_ADD_AT:       r.status = shadow_insert(c.pos, c.value);
      idxl_pkg::OP_REMOVE_END:   r.status = (shadow_count == 0) ? idxl_pkg::ST_EMPTY
                                            : shadow_remove(shadow_count - 1);
      idxl_pkg::OP_REMOVE_FRONT: r.status = shadow_remove(0);
      idxl_pkg::OP_REMOVE_AT:    r.status = shadow_remove(c.pos);
      idxl_pkg::OP_CLEAR:        shadow_count = 0;
      idxl_pkg::OP_CONTAINS:     r.found = (shadow_find(c.value) >= 0);
      idxl_pkg::OP_GET, idxl_pkg::OP_SET: begin
        if (shadow_count == 0) begin
          r.status = idxl_pkg::ST_EMPTY;
        end else if (c.pos >= shadow_count) begin
          r.status = idxl_pkg::ST_RANGE;
        end else if (c.op == idxl_pkg::OP_GET) begin
          r.value = shadow_list[c.pos];
        end else begin
          shadow_list[c.pos] = c.value;
        end
      end
      idxl_pkg::OP_SEARCH: begin
        hit = shadow_find(c.value);
        if (hit >= 0) begin
          r.found = 1'b1;
          r.pos = hit[idxl_pkg::RPOS_W-1:0];
        end else begin
          r.status = idxl_pkg::ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[idxl_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  // stimulus queue, with a running count estimate to steer positions
  task automatic queue_cmd(idxl_pkg::op_t op, logic [idxl_pkg::POS_W-1:0] pos,
                           logic [31:0] value);
    list_cmd_t c;
    c.op = op;
    c.pos = pos;
    c.value = value;
    case (op)
      idxl_pkg::OP_ADD_END, idxl_pkg::OP_ADD_FRONT: if (gen_count < LIST_DEPTH) gen_count++;
      idxl_pkg::OP_ADD_AT: if (pos <= gen_count && gen_count < LIST_DEPTH) gen_count++;
      idxl_pkg::OP_REMOVE_END, idxl_pkg::OP_REMOVE_FRONT: if (gen_count > 0) gen_count--;
      idxl_pkg::OP_REMOVE_AT: if (pos < gen_count) gen_count--;
      idxl_pkg::OP_CLEAR:     gen_count = 0;
      default: ;
    endcase
    pending_cmds.push_back(c);
  endtask

  task automatic queue_run(gen_mode_t mode, int n);
    idxl_pkg::op_t              op;
    logic [idxl_pkg::POS_W-1:0] pos;
    logic [31:0]                value;
    int                         roll;
    int                         k;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      case (mode)
        GEN_FILL:  op = (roll < 85)
                        ? idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_ADD_END,
                                                         idxl_pkg::OP_ADD_AT))
                        : idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_CONTAINS,
                                                         idxl_pkg::OP_SET));
        GEN_DRAIN: op = (roll < 80)
                        ? idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_REMOVE_END,
                                                         idxl_pkg::OP_REMOVE_AT))
                        : idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_CONTAINS,
                                                         idxl_pkg::OP_SET));
        GEN_MIX: begin
          op = idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_ADD_END, idxl_pkg::OP_SET));
          if (op == idxl_pkg::OP_CLEAR && roll >= 10) op = idxl_pkg::OP_SEARCH;
        end
        default:   op = idxl_pkg::op_t'($urandom_range(idxl_pkg::OP_ADD_END,
                                                       idxl_pkg::OP_SET));
      endcase
      roll = $urandom_range(0, 99);
      if (mode == GEN_NOISE || roll < 5) begin
        pos = idxl_pkg::POS_W'($urandom_range(0, LIST_DEPTH));
      end else if (roll < 15) begin
        pos = idxl_pkg::POS_W'($urandom_range(gen_count, LIST_DEPTH));
      end else begin
        pos = idxl_pkg::POS_W'($urandom_range(0, gen_count));
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        value = $urandom_range(0, 7) - 4;
      end else if (roll < 60) begin
        value = MARK_BASE | ((mode == GEN_FILL) ? gen_count % 256 : $urandom_range(0, 255));
      end else if (roll < 70) begin
        case ($urandom_range(0, 3))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7FFF_FFFF;
          2:       value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom;
      end
      queue_cmd(op, pos, value);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      failures++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_tdata <= {3'b000, next_cmd.value, next_cmd.pos, next_cmd.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      out_tready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check the result transfer, then predict the input transfer
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no expected result pending");
          failures++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[2:0]));
          check_field("found", 32'(want.found), 32'(out_tdata[3]));
          check_field("result_value", want.value, out_tdata[35:4]);
          check_field("result_position", 32'(want.pos), 32'(out_tdata[43:36]));
          check_field("element_count", 32'(want.count), 32'(out_tdata[52:44]));
        end
      end
      if (in_tvalid && in_tready) begin
        next_cmd.op = idxl_pkg::op_t'(in_tdata[3:0]);
        next_cmd.pos = in_tdata[12:4];
        next_cmd.value = in_tdata[44:13];
        expected_replies.push_back(apply_cmd(next_cmd));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("** indexed_list_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    // empty list corners
    queue_cmd(idxl_pkg::OP_GET, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_SET, 9'd0, 32'h1);
    queue_cmd(idxl_pkg::OP_REMOVE_END, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_REMOVE_FRONT, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_REMOVE_AT, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_SEARCH, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_CONTAINS, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_CLEAR, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_ADD_AT, 9'd1, 32'h5);
    // small list with extreme values
    queue_cmd(idxl_pkg::OP_ADD_END, 9'd0, 32'h7FFF_FFFF);
    queue_cmd(idxl_pkg::OP_ADD_FRONT, 9'd0, 32'h8000_0000);
    queue_cmd(idxl_pkg::OP_ADD_AT, 9'd1, 32'h0);
    queue_cmd(idxl_pkg::OP_ADD_AT, 9'd3, 32'hFFFF_FFFF);
    queue_cmd(idxl_pkg::OP_GET, 9'd256, 32'h0);
    queue_cmd(idxl_pkg::OP_GET, 9'd255, 32'h0);
    queue_cmd(idxl_pkg::OP_SET, 9'd2, 32'h1234_5678);
    queue_cmd(idxl_pkg::OP_SEARCH, 9'd0, 32'h8000_0000);
    queue_cmd(idxl_pkg::OP_SEARCH, 9'd0, 32'hFFFF_FFFF);
    queue_cmd(idxl_pkg::OP_CONTAINS, 9'd0, 32'h7FFF_FFFF);
    queue_cmd(idxl_pkg::OP_CONTAINS, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_REMOVE_AT, 9'd4, 32'h0);
    queue_cmd(idxl_pkg::OP_REMOVE_AT, 9'd1, 32'h0);
    queue_cmd(idxl_pkg::OP_REMOVE_END, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_GET, 9'd0, 32'h0);
    queue_cmd(idxl_pkg::OP_CLEAR, 9'd0, 32'h0);

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // slow receiver, list filled to capacity
    hold_asks = hold_asks + 1;
    queue_run(GEN_FILL, 340);
    queue_run(GEN_MIX, 120);
    queue_run(GEN_NOISE, 40);
    queue_run(GEN_DRAIN, 100);
    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    @(posedge clk);

    // slow sender, list drained past empty
    send_idle_pct = 72;
    recv_idle_pct = 24;
    hold_asks = hold_asks + 1;
    queue_run(GEN_MIX, 250);
    queue_run(GEN_DRAIN, 300);
    queue_run(GEN_NOISE, 50);
    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    @(posedge clk);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_run(GEN_FILL, 340);
    queue_run(GEN_MIX, 200);
    queue_run(GEN_NOISE, 60);
    queue_run(GEN_DRAIN, 100);
    while (pending_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("** indexed_list_engine_unit: PASSED **");
    end else begin
      $display("** indexed_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule : indexed_list_engine_unit_test
`default_nettype wire
